FILE: rtl/core/h2rgb_pkg.sv
// shared types, fixed-point constants and a code-to-fraction helper for the hsl to rgb converter
`default_nettype none

package h2rgb_pkg;

    // fractional bits of the internal unsigned fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int CODE_W    = 8;
    localparam int TDATA_W   = 3 * CODE_W;
    localparam int PROD_W    = 2 * FRAC_BITS;

    localparam longint ONE_I = 64'd1 << FRAC_BITS;

    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic signed [FRAC_BITS+1:0] hue_pos_t;

    localparam logic [FRAC_BITS:0] FX_ONE        = (FRAC_BITS+1)'(ONE_I);
    localparam frac_t              FX_MAX        = FRAC_BITS'(ONE_I - 64'd1);
    localparam frac_t              FX_THIRD      = FRAC_BITS'(ONE_I / 3);
    localparam frac_t              FX_SIXTH      = FRAC_BITS'(ONE_I / 6);
    localparam frac_t              FX_HALF       = FRAC_BITS'(ONE_I / 2);
    localparam frac_t              FX_TWO_THIRDS = FRAC_BITS'((2 * ONE_I) / 3);

    localparam hue_pos_t ONE_S   = $signed({1'b0, FX_ONE});
    localparam hue_pos_t THIRD_S = $signed({2'b00, FX_THIRD});

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // piece of the hue ramp that a channel falls on
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } seg_t;

    typedef struct packed {
        code_t hue;
        code_t saturation;
        code_t lightness;
    } pix_t;

    typedef struct packed {
        seg_t  seg;
        frac_t op;
    } ramp_op_t;

    typedef struct packed {
        logic            gray;
        frac_t           light;
        frac_t           p;
        frac_t           q;
        frac_t           span;
        ramp_op_t [2:0]  ch;
    } qp_t;

    typedef frac_t [2:0] chan_t;

    function automatic frac_t code_to_frac(input code_t code);
        return {code, {(FRAC_BITS-CODE_W){1'b0}}};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/h2rgb_qp.sv
// lightness-saturation product, q/p bounds and per-channel hue ramp setup
`default_nettype none

module h2rgb_qp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire h2rgb_pkg::pix_t in_pix,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output h2rgb_pkg::qp_t       out_qp
);
    import h2rgb_pkg::*;

    logic  valid_b_reg;
    pix_t  pix_b_reg;
    frac_t ls_b_reg;
    logic  valid_c_reg;
    qp_t   qp_c_reg;

    logic  en_b;
    logic  en_c;
    frac_t l_in;
    frac_t s_in;
    prod_t ls_prod;
    frac_t ls_next;

    frac_t                    lf;
    frac_t                    sf;
    frac_t                    hf;
    logic [FRAC_BITS+1:0]     q_raw;
    frac_t                    q_val;
    logic signed [FRAC_BITS+2:0] p_raw;
    frac_t                    p_val;
    hue_pos_t                 h_pos;
    qp_t                      qp_next;

    function automatic ramp_op_t ramp_setup(input hue_pos_t t_in);
        hue_pos_t             t;
        logic [FRAC_BITS:0]   tt;
        logic [FRAC_BITS:0]   d;
        logic [FRAC_BITS+2:0] x6;
        ramp_op_t             r;
        t = t_in;
        if (t < 0) begin
            t = t + ONE_S;
        end else if (t > ONE_S) begin
            t = t - ONE_S;
        end
        tt = t[FRAC_BITS:0];
        d  = {1'b0, FX_TWO_THIRDS} - tt;
        if (tt < {1'b0, FX_SIXTH}) begin
            x6    = {tt, 2'b00} + {1'b0, tt, 1'b0};
            r.seg = SEG_RISE;
            r.op  = x6[FRAC_BITS-1:0];
        end else if (tt < {1'b0, FX_HALF}) begin
            r.seg = SEG_HIGH;
            r.op  = '0;
        end else if (tt < {1'b0, FX_TWO_THIRDS}) begin
            x6    = {d, 2'b00} + {1'b0, d, 1'b0};
            r.seg = SEG_FALL;
            r.op  = x6[FRAC_BITS-1:0];
        end else begin
            r.seg = SEG_LOW;
            r.op  = '0;
        end
        return r;
    endfunction

    assign en_c     = !valid_c_reg || out_ready;
    assign en_b     = !valid_b_reg || en_c;
    assign in_ready = en_b;

    // stage b: l * s
    assign l_in    = code_to_frac(in_pix.lightness);
    assign s_in    = code_to_frac(in_pix.saturation);
    assign ls_prod = l_in * s_in;
    assign ls_next = ls_prod[PROD_W-1:FRAC_BITS];

    // stage c: q, p and ramp operands
    always_comb begin
        lf = code_to_frac(pix_b_reg.lightness);
        sf = code_to_frac(pix_b_reg.saturation);
        hf = code_to_frac(pix_b_reg.hue);
        if (lf < FX_HALF) begin
            q_raw = {2'b00, lf} + {2'b00, ls_b_reg};
        end else begin
            q_raw = {2'b00, lf} + {2'b00, sf} - {2'b00, ls_b_reg};
        end
        q_val = (q_raw > {2'b00, FX_MAX}) ? FX_MAX : q_raw[FRAC_BITS-1:0];
        p_raw = $signed({2'b00, lf, 1'b0}) - $signed({3'b000, q_val});
        if (p_raw < 0) begin
            p_val = '0;
        end else if (p_raw[FRAC_BITS+1:0] > {2'b00, q_val}) begin
            p_val = q_val;
        end else begin
            p_val = p_raw[FRAC_BITS-1:0];
        end
        h_pos = $signed({2'b00, hf});
        qp_next.gray         = (pix_b_reg.saturation == '0);
        qp_next.light        = lf;
        qp_next.p            = p_val;
        qp_next.q            = q_val;
        qp_next.span         = q_val - p_val;
        qp_next.ch[CH_RED]   = ramp_setup(h_pos + THIRD_S);
        qp_next.ch[CH_GREEN] = ramp_setup(h_pos);
        qp_next.ch[CH_BLUE]  = ramp_setup(h_pos - THIRD_S);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else begin
            if (en_b) begin
                valid_b_reg <= in_valid;
            end
            if (en_c) begin
                valid_c_reg <= valid_b_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            pix_b_reg <= in_pix;
            ls_b_reg  <= ls_next;
        end
        if (en_c) begin
            qp_c_reg <= qp_next;
        end
    end

    assign out_valid = valid_c_reg;
    assign out_qp    = qp_c_reg;

    a_p_below_q: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_c_reg |-> (qp_c_reg.p <= qp_c_reg.q)
                        && (qp_c_reg.span == qp_c_reg.q - qp_c_reg.p))
        else $error("p/q bounds inconsistent");

endmodule

`default_nettype wire

FILE: rtl/core/h2rgb_ramp.sv
// ramp products and channel fraction selection
`default_nettype none

module h2rgb_ramp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire h2rgb_pkg::qp_t in_qp,
    output logic                out_valid,
    input  wire logic           out_ready,
    output h2rgb_pkg::chan_t    out_chan
);
    import h2rgb_pkg::*;

    logic        valid_d_reg;
    prod_t [2:0] prod_d_reg;
    seg_t  [2:0] seg_d_reg;
    frac_t       p_d_reg;
    frac_t       q_d_reg;
    frac_t       l_d_reg;
    logic        gray_d_reg;
    logic        valid_e_reg;
    chan_t       chan_e_reg;

    logic               en_d;
    logic               en_e;
    prod_t [2:0]        prod_next;
    chan_t              chan_next;
    logic [FRAC_BITS:0] v_raw [3];

    assign en_e     = !valid_e_reg || out_ready;
    assign en_d     = !valid_d_reg || en_e;
    assign in_ready = en_d;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod_next[c] = in_qp.span * in_qp.ch[c].op;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            unique case (seg_d_reg[c])
                SEG_RISE, SEG_FALL:
                    v_raw[c] = {1'b0, p_d_reg} + {1'b0, prod_d_reg[c][PROD_W-1:FRAC_BITS]};
                SEG_HIGH: v_raw[c] = {1'b0, q_d_reg};
                SEG_LOW:  v_raw[c] = {1'b0, p_d_reg};
                default:  v_raw[c] = {1'b0, p_d_reg};
            endcase
            if (gray_d_reg) begin
                v_raw[c] = {1'b0, l_d_reg};
            end
            chan_next[c] = (v_raw[c] > {1'b0, FX_MAX}) ? FX_MAX : v_raw[c][FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end else begin
            if (en_d) begin
                valid_d_reg <= in_valid;
            end
            if (en_e) begin
                valid_e_reg <= valid_d_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            prod_d_reg <= prod_next;
            for (int c = 0; c < 3; c++) begin
                seg_d_reg[c] <= in_qp.ch[c].seg;
            end
            p_d_reg    <= in_qp.p;
            q_d_reg    <= in_qp.q;
            l_d_reg    <= in_qp.light;
            gray_d_reg <= in_qp.gray;
        end
        if (en_e) begin
            chan_e_reg <= chan_next;
        end
    end

    assign out_valid = valid_e_reg;
    assign out_chan  = chan_e_reg;

    // the scaled edge never climbs past q
    a_edge_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_d_reg |->
            (prod_d_reg[CH_RED][PROD_W-1:FRAC_BITS] <= q_d_reg - p_d_reg)
            && (prod_d_reg[CH_GREEN][PROD_W-1:FRAC_BITS] <= q_d_reg - p_d_reg)
            && (prod_d_reg[CH_BLUE][PROD_W-1:FRAC_BITS] <= q_d_reg - p_d_reg))
        else $error("ramp edge exceeds q-p span");

endmodule

`default_nettype wire

FILE: rtl/core/h2rgb_out.sv
// scaling of channel fractions to bytes and output register
`default_nettype none

module h2rgb_out (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire h2rgb_pkg::chan_t                   in_chan,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [h2rgb_pkg::TDATA_W-1:0]           out_data
);
    import h2rgb_pkg::*;

    logic               valid_f_reg;
    logic [TDATA_W-1:0] data_f_reg;

    logic                        en_f;
    logic [TDATA_W-1:0]          data_next;
    logic [FRAC_BITS+CODE_W-1:0] scaled [3];

    assign en_f     = !valid_f_reg || out_ready;
    assign in_ready = en_f;

    // v * 255 as (v << 8) - v, then keep the integer part
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            scaled[c] = {in_chan[c], {CODE_W{1'b0}}} - {{CODE_W{1'b0}}, in_chan[c]};
            data_next[c*CODE_W +: CODE_W] = scaled[c][FRAC_BITS+CODE_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_f_reg <= 1'b0;
        end else if (en_f) begin
            valid_f_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_f) begin
            data_f_reg <= data_next;
        end
    end

    assign out_valid = valid_f_reg;
    assign out_data  = data_f_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hsl_to_rgb_converter.sv
// HSL to RGB pixel converter, top level
//
// Converts one pixel per clock from 8-bit hue, saturation and lightness (each read
// as code/256) to 8-bit red, green and blue, computed in unsigned fixed point with
// h2rgb_pkg::FRAC_BITS fractional bits and truncation at every product. The block is
// a six-stage pipeline (input register, l*s product, q/p and ramp setup, ramp
// products, channel select, byte scaling and output register), and it takes a new
// pixel every cycle unless the full pipeline is stalled from the output side.
// Each stage has its own valid bit and stalls only when the stage after it is full,
// so m_tready low only blocks s_tready once the whole pipeline has filled up.
`default_nettype none

module hsl_to_rgb_converter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [h2rgb_pkg::TDATA_W-1:0]  s_tdata,  // hue, saturation, lightness
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [h2rgb_pkg::TDATA_W-1:0]       m_tdata   // red, green, blue
);
    import h2rgb_pkg::*;

    logic  valid_a_reg;
    pix_t  pix_a_reg;
    logic  en_a;
    pix_t  pix_next;

    logic  qp_in_ready;
    logic  qp_valid;
    qp_t   qp_data;
    logic  ramp_in_ready;
    logic  ramp_valid;
    chan_t ramp_chan;
    logic  out_in_ready;

    assign en_a     = !valid_a_reg || qp_in_ready;
    assign s_tready = en_a;

    assign pix_next.hue        = s_tdata[0*CODE_W +: CODE_W];
    assign pix_next.saturation = s_tdata[1*CODE_W +: CODE_W];
    assign pix_next.lightness  = s_tdata[2*CODE_W +: CODE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (en_a) begin
            valid_a_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            pix_a_reg <= pix_next;
        end
    end

    h2rgb_qp u_qp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_a_reg),
        .in_ready  (qp_in_ready),
        .in_pix    (pix_a_reg),
        .out_valid (qp_valid),
        .out_ready (ramp_in_ready),
        .out_qp    (qp_data)
    );

    h2rgb_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qp_valid),
        .in_ready  (ramp_in_ready),
        .in_qp     (qp_data),
        .out_valid (ramp_valid),
        .out_ready (out_in_ready),
        .out_chan  (ramp_chan)
    );

    h2rgb_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ramp_valid),
        .in_ready  (out_in_ready),
        .in_chan   (ramp_chan),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // input side only backs up when the output is full and held
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side is free");

    a_fill_after_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_a_reg && qp_valid && ramp_valid))
        else $error("input stalled with a bubble in the pipeline");

    a_first_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_a_reg && qp_in_ready) |-> s_tready)
        else $error("input stage blocked while it can drain");

endmodule

`default_nettype wire

FILE: tb/tb_hsl_to_rgb_converter.sv
// self-checking testbench for the hsl to rgb pixel converter
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter;

    import h2rgb_pkg::code_t;

    localparam int     FB           = h2rgb_pkg::FRAC_BITS;
    localparam longint UNIT         = longint'(1) << FB;
    localparam longint THIRD        = UNIT / 3;
    localparam longint SIXTH        = UNIT / 6;
    localparam longint HALF         = UNIT / 2;
    localparam longint TWO_THIRDS   = (2 * UNIT) / 3;
    localparam int     IDLE_LIMIT   = 5000;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     RANDOM_ITEMS = 1150;
    localparam int     HOLD_ITEMS   = 80;
    localparam int     HOLD_CYCLES  = 200;

    typedef struct packed {
        code_t red;
        code_t green;
        code_t blue;
    } rgb_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [h2rgb_pkg::TDATA_W-1:0]      s_tdata  = '0;  // hue, saturation, lightness
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [h2rgb_pkg::TDATA_W-1:0]      m_tdata;        // red, green, blue

    rgb_t pending_rgb [$];
    int   fail_count     = 0;
    int   idle_cycles    = 0;
    int   hold_request   = 0;
    bit   src_gaps_on    = 1'b1;
    bit   sink_stalls_on = 1'b1;

    hsl_to_rgb_converter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- fixed-point color math ----------------

    function automatic longint clamp_frac(longint v);
        if (v < 0) return 0;
        if (v > UNIT - 1) return UNIT - 1;
        return v;
    endfunction

    // piecewise hue ramp between p and q at hue position t
    function automatic longint ramp_level(longint p, longint q, longint t);
        longint span;
        span = q - p;
        if (t < 0) t += UNIT;
        if (t > UNIT) t -= UNIT;
        if (t < SIXTH)
            return p + ((span * 6 * t) >> FB);
        if (t < HALF)
            return q;
        if (t < TWO_THIRDS)
            return p + ((span * (TWO_THIRDS - t) * 6) >> FB);
        return p;
    endfunction

    function automatic code_t frac_to_code(longint v);
        longint c;
        c = (clamp_frac(v) * 255) >> FB;
        if (c > 255) c = 255;
        return code_t'(c);
    endfunction

    function automatic rgb_t hsl_to_rgb(code_t hue, code_t sat, code_t light);
        longint h, s, l, ls, q, p, r, g, b;
        rgb_t   px;
        h = longint'(hue) << (FB - 8);
        s = longint'(sat) << (FB - 8);
        l = longint'(light) << (FB - 8);
        if (s == 0) begin
            r = l;
            g = l;
            b = l;
        end else begin
            ls = (l * s) >> FB;
            q  = clamp_frac((l < HALF) ? l + ls : l + s - ls);
            p  = 2 * l - q;
            if (p < 0) p = 0;
            if (p > q) p = q;
            r = ramp_level(p, q, h + THIRD);
            g = ramp_level(p, q, h);
            b = ramp_level(p, q, h - THIRD);
        end
        px.red   = frac_to_code(r);
        px.green = frac_to_code(g);
        px.blue  = frac_to_code(b);
        return px;
    endfunction

    // mostly back-to-back, sometimes short, rarely long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- input side ----------------

    task automatic send_pixel(code_t hue, code_t sat, code_t light);
        int gap;
        s_tdata  <= {light, sat, hue};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_rgb.push_back(hsl_to_rgb(hue, sat, light));
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------- result side ----------------

    initial begin : result_sink
        int   stall_left;
        int   hold_left;
        rgb_t got;
        rgb_t want;
        stall_left = 0;
        hold_left  = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.red   = m_tdata[7:0];
                got.green = m_tdata[15:8];
                got.blue  = m_tdata[23:16];
                if (pending_rgb.size() == 0) begin
                    $error("unexpected result transaction: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_rgb.pop_front();
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left == 0 && stall_left == 0 && sink_stalls_on &&
                $urandom_range(0, 4) == 0)
                stall_left = pick_gap();
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ends the run when neither side moves a transaction for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed_corners();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        // grey cases: saturation zero, or full saturation with lightness at either end
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd0,   8'd128);
        send_pixel(8'd123, 8'd0,   8'd77);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        // hue at the edges of each ramp piece
        send_pixel(8'd0,   8'd255, 8'd128);
        send_pixel(8'd42,  8'd255, 8'd128);
        send_pixel(8'd43,  8'd255, 8'd128);
        send_pixel(8'd85,  8'd255, 8'd128);
        send_pixel(8'd86,  8'd255, 8'd128);
        send_pixel(8'd127, 8'd255, 8'd128);
        send_pixel(8'd128, 8'd255, 8'd128);
        send_pixel(8'd170, 8'd255, 8'd128);
        send_pixel(8'd171, 8'd255, 8'd128);
        send_pixel(8'd213, 8'd255, 8'd128);
        send_pixel(8'd214, 8'd255, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd128);
        // lightness on both sides of one half, then low-saturation and mixed pixels
        send_pixel(8'd20,  8'd200, 8'd127);
        send_pixel(8'd20,  8'd200, 8'd128);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd254);
        send_pixel(8'd200, 8'd128, 8'd64);
        stop_sending();
    endtask

    task automatic test_random_pixels();
        code_t hue, sat, light;
        int    roll;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                src_gaps_on    = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            hue   = code_t'($urandom_range(0, 255));
            sat   = code_t'($urandom_range(0, 255));
            light = code_t'($urandom_range(0, 255));
            roll  = $urandom_range(0, 9);
            case (roll)
                0: begin
                    sat = '0;
                end
                1: begin
                    light = code_t'($urandom_range(0, 1) ? $urandom_range(126, 129)
                                                          : $urandom_range(0, 1) * 255);
                end
                2: begin
                    // land near a piece boundary of one of the three ramps
                    hue = code_t'(42 * $urandom_range(0, 6) + $urandom_range(0, 2));
                end
                default: begin
                end
            endcase
            send_pixel(hue, sat, light);
        end
        stop_sending();
    endtask

    task automatic test_output_backpressure();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        hold_request   = HOLD_CYCLES;
        @(posedge aclk);
        for (int i = 0; i < HOLD_ITEMS; i++)
            send_pixel(code_t'($urandom_range(0, 255)), code_t'($urandom_range(0, 255)),
                       code_t'($urandom_range(0, 255)));
        stop_sending();
        sink_stalls_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_random_pixels();
        test_output_backpressure();
        wait (pending_rgb.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
